FILE: hw/rtl/wpd_pkg.sv
`default_nettype none

package wpd_pkg;

  // Sizes
  localparam int MAX_CHANNELS = 8;
  localparam int HEADER_BYTES = 44;
  localparam int POS_W = 6;
  localparam int IDX_W = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W = 17 + $clog2(MAX_CHANNELS);
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Header byte positions
  localparam logic [POS_W-1:0] POS_FMT_LO = POS_W'(20);
  localparam logic [POS_W-1:0] POS_FMT_HI = POS_W'(21);
  localparam logic [POS_W-1:0] POS_CH_LO = POS_W'(22);
  localparam logic [POS_W-1:0] POS_CH_HI = POS_W'(23);
  localparam logic [POS_W-1:0] POS_RATE_LO = POS_W'(24);
  localparam logic [POS_W-1:0] POS_RATE_END = POS_W'(28);
  localparam logic [POS_W-1:0] POS_BITS_LO = POS_W'(34);
  localparam logic [POS_W-1:0] POS_BITS_HI = POS_W'(35);
  localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HEADER_BYTES);

  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] BITS_16 = 16'd16;
  localparam logic [31:0] RATE_RESET = 32'd44100;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_NOT_PCM = 3'd2;
  localparam logic [2:0] ST_BITS = 3'd3;
  localparam logic [2:0] ST_CHANNELS = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;
    logic load_main;
    logic main_sample;
    logic main_last;
    logic load_end;
  } wpd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_done;
    logic frame_done;
    logic div_busy;
    logic out_free;
  } wpd_stat_t;

  // Expected magic byte and whether the position is checked
  function automatic logic [8:0] magic_byte(input logic [POS_W-1:0] pos);
    logic [8:0] r;
    r = 9'h000;
    case (pos)
      6'd0: r = {1'b1, 8'h52};
      6'd1: r = {1'b1, 8'h49};
      6'd2: r = {1'b1, 8'h46};
      6'd3: r = {1'b1, 8'h46};
      6'd8: r = {1'b1, 8'h57};
      6'd9: r = {1'b1, 8'h41};
      6'd10: r = {1'b1, 8'h56};
      6'd11: r = {1'b1, 8'h45};
      default: r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wpd_div.sv
`default_nettype none

// Bit-serial signed divide, one quotient bit per cycle, truncates toward zero
module wpd_div (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic signed [wpd_pkg::SUM_W-1:0] dividend,
  input wire logic [wpd_pkg::IDX_W-1:0] divisor,
  output logic busy,
  output logic signed [15:0] quotient
);

  logic [wpd_pkg::DIV_CNT_W-1:0] cnt;
  logic [wpd_pkg::IDX_W:0] rem;
  logic [wpd_pkg::SUM_W-1:0] quo;
  logic [wpd_pkg::IDX_W-1:0] dvs;
  logic neg;

  logic [wpd_pkg::IDX_W:0] rem_sh;
  logic ge;
  logic [wpd_pkg::SUM_W-1:0] mag;

  // Shift in the next dividend bit and trial subtract
  always_comb begin
    rem_sh = {rem[wpd_pkg::IDX_W-1:0], quo[wpd_pkg::SUM_W-1]};
    ge = rem_sh >= {1'b0, dvs};
    mag = dividend[wpd_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
  end

  // Control: run for SUM_W steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= wpd_pkg::DIV_CNT_W'(wpd_pkg::SUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == wpd_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag;
      dvs <= divisor;
      neg <= dividend[wpd_pkg::SUM_W-1];
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quo <= {quo[wpd_pkg::SUM_W-2:0], ge};
    end
  end

  assign quotient = neg ? (16'sd0 - $signed(quo[15:0])) : $signed(quo[15:0]);

endmodule

`default_nettype wire

FILE: hw/rtl/wpd_dp.sv
`default_nettype none

module wpd_dp (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_write_en,
  input wire logic [31:0] cfg_write_data,
  input wire logic [7:0] in_byte,
  input wire wpd_pkg::wpd_cmd_t cmd,
  output wpd_pkg::wpd_stat_t stat,
  output logic out_valid,
  input wire logic out_ready,
  output logic [1:0] kind,
  output logic signed [15:0] mono_sample,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [15:0] bits_per_sample,
  output logic [2:0] status,
  output logic rate_mismatch,
  output logic last
);

  logic [31:0] expected_rate;
  logic [wpd_pkg::POS_W-1:0] byte_position;
  logic magic_ok;
  logic [15:0] format_word;
  logic [15:0] channels_held;
  logic [31:0] rate_held;
  logic [15:0] bits_held;
  logic [7:0] low_byte_held;
  logic byte_phase;
  logic [wpd_pkg::IDX_W-1:0] channel_index;
  logic signed [wpd_pkg::SUM_W-1:0] frame_sum;

  logic in_header;
  logic supported;
  logic [8:0] magic;
  logic signed [15:0] sample_in;
  logic signed [wpd_pkg::SUM_W-1:0] sum_next;
  logic [wpd_pkg::IDX_W-1:0] idx_inc;
  logic frame_done;
  logic [2:0] hdr_status;
  logic div_busy;
  logic signed [15:0] div_q;
  logic [1:0] rate_sh;
  logic out_free;

  // Header checks and sample assembly
  always_comb begin
    in_header = byte_position < wpd_pkg::POS_HDR_END;
    supported = (channels_held >= 16'd1) && (channels_held <= 16'(wpd_pkg::MAX_CHANNELS));
    magic = wpd_pkg::magic_byte(byte_position);
    sample_in = $signed({in_byte, low_byte_held});
    sum_next = frame_sum + wpd_pkg::SUM_W'(sample_in);
    idx_inc = channel_index + 1'b1;
    frame_done = !in_header && byte_phase && (bits_held == wpd_pkg::BITS_16) && supported
                 && (16'(idx_inc) >= channels_held);
    rate_sh = 2'(byte_position - wpd_pkg::POS_RATE_LO);
    out_free = !out_valid || out_ready;
  end

  // Status priority: truncated, magic, format, bits, channels
  always_comb begin
    if (in_header) begin
      hdr_status = wpd_pkg::ST_TRUNC;
    end else if (!magic_ok) begin
      hdr_status = wpd_pkg::ST_BAD_MAGIC;
    end else if (format_word != wpd_pkg::FMT_PCM) begin
      hdr_status = wpd_pkg::ST_NOT_PCM;
    end else if (bits_held != wpd_pkg::BITS_16) begin
      hdr_status = wpd_pkg::ST_BITS;
    end else if (!supported) begin
      hdr_status = wpd_pkg::ST_CHANNELS;
    end else begin
      hdr_status = wpd_pkg::ST_OK;
    end
  end

  assign stat.hdr_done = (byte_position == wpd_pkg::POS_HDR_LAST);
  assign stat.frame_done = frame_done;
  assign stat.div_busy = div_busy;
  assign stat.out_free = out_free;

  // Hold the expected rate
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_rate <= wpd_pkg::RATE_RESET;
    end else if (cfg_write_en) begin
      expected_rate <= cfg_write_data;
    end
  end

  // Advance the parse state per byte; clear after the end status
  always_ff @(posedge clk) begin
    if (rst || cmd.load_end) begin
      byte_position <= '0;
      magic_ok <= 1'b1;
      format_word <= '0;
      channels_held <= '0;
      rate_held <= '0;
      bits_held <= '0;
      low_byte_held <= '0;
      byte_phase <= 1'b0;
      channel_index <= '0;
      frame_sum <= '0;
    end else if (cmd.take_byte) begin
      if (in_header) begin
        byte_position <= byte_position + 1'b1;
        if (magic[8] && (magic[7:0] != in_byte)) begin
          magic_ok <= 1'b0;
        end
        if (byte_position == wpd_pkg::POS_FMT_LO) format_word[7:0] <= in_byte;
        if (byte_position == wpd_pkg::POS_FMT_HI) format_word[15:8] <= in_byte;
        if (byte_position == wpd_pkg::POS_CH_LO) channels_held[7:0] <= in_byte;
        if (byte_position == wpd_pkg::POS_CH_HI) channels_held[15:8] <= in_byte;
        if (byte_position >= wpd_pkg::POS_RATE_LO && byte_position < wpd_pkg::POS_RATE_END) begin
          rate_held[rate_sh*8 +: 8] <= in_byte;
        end
        if (byte_position == wpd_pkg::POS_BITS_LO) bits_held[7:0] <= in_byte;
        if (byte_position == wpd_pkg::POS_BITS_HI) bits_held[15:8] <= in_byte;
      end else if (!byte_phase) begin
        low_byte_held <= in_byte;
        byte_phase <= 1'b1;
      end else begin
        byte_phase <= 1'b0;
        if (bits_held == wpd_pkg::BITS_16 && supported) begin
          if (frame_done) begin
            frame_sum <= '0;
            channel_index <= '0;
          end else begin
            frame_sum <= sum_next;
            channel_index <= idx_inc;
          end
        end
      end
    end
  end

  wpd_div u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.take_byte && frame_done),
    .dividend(sum_next),
    .divisor(channels_held[wpd_pkg::IDX_W-1:0]),
    .busy(div_busy),
    .quotient(div_q)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_main || cmd.load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result fields
  always_ff @(posedge clk) begin
    if (cmd.load_main || cmd.load_end) begin
      channel_count <= channels_held;
      sample_rate <= rate_held;
      bits_per_sample <= bits_held;
      status <= hdr_status;
      rate_mismatch <= rate_held != expected_rate;
      if (cmd.load_end) begin
        kind <= wpd_pkg::KIND_END;
        mono_sample <= '0;
        last <= 1'b1;
      end else begin
        kind <= cmd.main_sample ? wpd_pkg::KIND_SAMPLE : wpd_pkg::KIND_HEADER;
        mono_sample <= cmd.main_sample ? div_q : 16'sd0;
        last <= cmd.main_last;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wpd_ctrl.sv
`default_nettype none

module wpd_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic last_byte,
  input wire wpd_pkg::wpd_stat_t stat,
  output wpd_pkg::wpd_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_MAIN = 2'd2;
  localparam logic [1:0] S_END = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic end_pending;
  logic end_pending_next;
  logic main_sample;
  logic main_sample_next;

  assign in_ready = (state == S_IDLE);

  // Sequence: take a request, divide if a frame closed, then issue results
  always_comb begin
    state_next = state;
    end_pending_next = end_pending;
    main_sample_next = main_sample;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          end_pending_next = last_byte;
          main_sample_next = stat.frame_done;
          if (stat.frame_done) begin
            state_next = S_DIV;
          end else if (stat.hdr_done) begin
            state_next = S_MAIN;
          end else if (last_byte) begin
            state_next = S_END;
          end
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_MAIN;
        end
      end
      S_MAIN: begin
        if (stat.out_free) begin
          cmd.load_main = 1'b1;
          cmd.main_sample = main_sample;
          cmd.main_last = !end_pending;
          state_next = end_pending ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.load_end = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      end_pending <= 1'b0;
      main_sample <= 1'b0;
    end else begin
      state <= state_next;
      end_pending <= end_pending_next;
      main_sample <= main_sample_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wav_pcm16_mono_downmix_top.sv
// WAV PCM16 header check and mono downmix. Feed the file one byte per request,
// header first, with last_byte on the final byte. The 44-byte header is checked
// and a header summary comes out on its last byte; after that, 16-bit
// little-endian samples of one interleaved frame are summed and the channel
// average comes out, truncated toward zero. The byte with last_byte set gives
// its own result, if any, then an end status, and the block returns to the
// start of a new file (expected_rate is kept). The block takes no new byte until
// the results of the byte before are issued. A byte that completes a frame waits
// for the bit-serial divider, which forms the average one quotient bit per cycle
// for any channel count; the last byte then also issues the end status. A result
// waiting on out_ready holds the block only when a new result must be loaded
// behind it.
`default_nettype none

module wav_pcm16_mono_downmix_top (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_write_en,
  input wire logic [31:0] cfg_write_data,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [7:0] in_byte,
  input wire logic last_byte,
  output logic out_valid,
  input wire logic out_ready,
  output logic [1:0] kind,
  output logic signed [15:0] mono_sample,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [15:0] bits_per_sample,
  output logic [2:0] status,
  output logic rate_mismatch,
  output logic last
);

  wpd_pkg::wpd_cmd_t cmd;
  wpd_pkg::wpd_stat_t stat;

  wpd_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .last_byte(last_byte),
    .stat(stat),
    .cmd(cmd)
  );

  wpd_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_byte(in_byte),
    .cmd(cmd),
    .stat(stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .mono_sample(mono_sample),
    .channel_count(channel_count),
    .sample_rate(sample_rate),
    .bits_per_sample(bits_per_sample),
    .status(status),
    .rate_mismatch(rate_mismatch),
    .last(last)
  );

endmodule

`default_nettype wire
